// ----- src/upc_pkg.sv -----
// Shared widths, register codes, CORDIC constants and stage types for the point controller.
`timescale 1ns / 1ps
package upc_pkg;

   // CORDIC depth and arctangent table
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

   // Field and datapath widths
   localparam int COORD_W     = 20;
   localparam int HEAD_W      = 18;
   localparam int DIFF_W      = 21;
   localparam int SQ_W        = 42;
   localparam int TOLSQ_W     = 38;
   localparam int ROOT_W      = 21;
   localparam int ROOT_STAGES = 21;
   localparam int CX_W        = 34;
   localparam int ERR_W       = 35;
   localparam int E_W         = 18;
   localparam int W_W         = 21;
   localparam int R_W         = 25;
   localparam int KD_W        = 26;
   localparam int COS_W       = 32;
   localparam int SPD_W       = 20;
   localparam int GAIN_W      = 16;
   localparam int LEN_W       = 19;

   // Stream and register port widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_LIM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_LIM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_TOL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_ARM    = 3'd5;

   // Angle constants in Q3.29 and the CORDIC gain in Q2.30
   localparam logic signed [CX_W-1:0]  PI_Q29      = 34'sd1686629713;
   localparam logic signed [CX_W-1:0]  HALF_PI_Q29 = 34'sd843314857;
   localparam logic signed [ERR_W-1:0] PI_E        = 35'sd1686629713;
   localparam logic signed [ERR_W-1:0] TWO_PI_E    = 35'sd3373259426;
   localparam logic signed [ERR_W-1:0] FOUR_PI_E   = 35'sd6746518852;
   localparam logic signed [CX_W-1:0]  CORDIC_K    = 34'sd652032874;

   // Sideband carried through the bearing CORDIC
   typedef struct packed {
      logic [SQ_W-1:0]          s;
      logic                     near;
      logic signed [HEAD_W-1:0] head;
   } vec_side_type;

   // Sideband carried through the square root
   typedef struct packed {
      logic signed [CX_W-1:0]   z;
      logic                     near;
      logic signed [HEAD_W-1:0] head;
   } root_side_type;

   // Sideband carried through the cosine CORDIC
   typedef struct packed {
      logic                  near;
      logic [KD_W-1:0]       kd;
      logic signed [R_W-1:0] r;
   } cos_side_type;

   // Arctangent of 2^-i in Q3.29
   function automatic logic signed [CX_W-1:0] atan_q29(input int idx);
      logic signed [CX_W-1:0] val;
      unique case (idx)
         0:  val = 34'sd421657428;
         1:  val = 34'sd248918915;
         2:  val = 34'sd131521918;
         3:  val = 34'sd66762579;
         4:  val = 34'sd33510843;
         5:  val = 34'sd16771758;
         6:  val = 34'sd8387925;
         7:  val = 34'sd4194219;
         8:  val = 34'sd2097141;
         9:  val = 34'sd1048575;
         10: val = 34'sd524288;
         11: val = 34'sd262144;
         12: val = 34'sd131072;
         13: val = 34'sd65536;
         14: val = 34'sd32768;
         15: val = 34'sd16384;
         16: val = 34'sd8192;
         17: val = 34'sd4096;
         18: val = 34'sd2048;
         19: val = 34'sd1024;
         20: val = 34'sd512;
         21: val = 34'sd256;
         22: val = 34'sd128;
         23: val = 34'sd64;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- src/upc_vec_cordic.sv -----
// Pipelined vectoring CORDIC that finds the bearing of the vector to the target.
`timescale 1ns / 1ps
module upc_vec_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [upc_pkg::DIFF_W-1:0]  in_dx,
   input  logic signed [upc_pkg::DIFF_W-1:0]  in_dy,
   input  upc_pkg::vec_side_type              in_side,
   output logic                               out_valid,
   output logic signed [upc_pkg::CX_W-1:0]    out_z,
   output upc_pkg::vec_side_type              out_side
);

   localparam int N = upc_pkg::CORDIC_ITERS;

   logic                             vld_ff  [0:N];
   logic signed [upc_pkg::CX_W-1:0]  x_ff    [0:N];
   logic signed [upc_pkg::CX_W-1:0]  y_ff    [0:N];
   logic signed [upc_pkg::CX_W-1:0]  z_ff    [0:N];
   upc_pkg::vec_side_type            side_ff [0:N];

   logic signed [upc_pkg::CX_W-1:0]  x0_in, y0_in, z0_in;

   // Scale to Q.24 and fold the left half plane by a half turn.
   always_comb begin
      x0_in = {{5{in_dx[upc_pkg::DIFF_W-1]}}, in_dx, 8'b0};
      y0_in = {{5{in_dy[upc_pkg::DIFF_W-1]}}, in_dy, 8'b0};
      z0_in = '0;
      if (in_dx[upc_pkg::DIFF_W-1]) begin
         z0_in = in_dy[upc_pkg::DIFF_W-1] ? -upc_pkg::PI_Q29 : upc_pkg::PI_Q29;
         x0_in = -x0_in;
         y0_in = -y0_in;
      end
   end

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         side_ff[0] <= in_side;
      end
   end

   // One micro-rotation per stage, driving y toward zero.
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [upc_pkg::CX_W-1:0] xs, ys;
      logic signed [upc_pkg::CX_W-1:0] x_in, y_in, z_in;
      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!y_ff[i][upc_pkg::CX_W-1]) begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + upc_pkg::atan_q29(i);
         end else begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - upc_pkg::atan_q29(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_z     = z_ff[N];
   assign out_side  = side_ff[N];

endmodule

// ----- src/upc_isqrt.sv -----
// Pipelined digit-by-digit integer square root, one result bit per stage.
`timescale 1ns / 1ps
module upc_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [upc_pkg::SQ_W-1:0]       in_s,
   input  upc_pkg::root_side_type         in_side,
   output logic                           out_valid,
   output logic [upc_pkg::ROOT_W-1:0]     out_root,
   output upc_pkg::root_side_type         out_side
);

   localparam int N = upc_pkg::ROOT_STAGES;

   logic                           vld_ff  [0:N];
   logic [upc_pkg::SQ_W-1:0]       rem_ff  [0:N];
   logic [upc_pkg::SQ_W-1:0]       res_ff  [0:N];
   upc_pkg::root_side_type         side_ff [0:N];

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]  <= in_s;
         res_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   // Each stage tries the next bit of the root.
   for (genvar k = 0; k < N; k++) begin : g_digit
      localparam logic [upc_pkg::SQ_W-1:0] StepBit =
         upc_pkg::SQ_W'(1) << (2 * (N - 1 - k));
      logic [upc_pkg::SQ_W:0]   trial;
      logic [upc_pkg::SQ_W-1:0] rem_in, res_in;
      always_comb begin
         trial = {1'b0, res_ff[k]} + {1'b0, StepBit};
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in = rem_ff[k] - trial[upc_pkg::SQ_W-1:0];
            res_in = (res_ff[k] >> 1) + StepBit;
         end else begin
            rem_in = rem_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (adv) begin
            rem_ff[k+1]  <= rem_in;
            res_ff[k+1]  <= res_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = res_ff[N][upc_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[N];

endmodule

// ----- src/upc_cos_cordic.sv -----
// Pipelined rotation CORDIC that gives the cosine of the heading error in Q2.30.
`timescale 1ns / 1ps
module upc_cos_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [upc_pkg::E_W-1:0]     in_angle,
   input  upc_pkg::cos_side_type              in_side,
   output logic                               out_valid,
   output logic signed [upc_pkg::COS_W-1:0]   out_cos,
   output upc_pkg::cos_side_type              out_side
);

   localparam int N = upc_pkg::CORDIC_ITERS;

   logic                             vld_ff  [0:N];
   logic signed [upc_pkg::CX_W-1:0]  x_ff    [0:N];
   logic signed [upc_pkg::CX_W-1:0]  y_ff    [0:N];
   logic signed [upc_pkg::CX_W-1:0]  a_ff    [0:N];
   logic                             neg_ff  [0:N];
   upc_pkg::cos_side_type            side_ff [0:N];

   logic signed [upc_pkg::CX_W-1:0]  a_wide, a0_in;
   logic                             neg0_in;
   logic                             out_vld_ff;
   logic signed [upc_pkg::COS_W-1:0] cos_ff;
   upc_pkg::cos_side_type            out_side_ff;

   // Move the angle into the right half plane; the result is then negated.
   always_comb begin
      a_wide  = {{2{in_angle[upc_pkg::E_W-1]}}, in_angle, 14'b0};
      a0_in   = a_wide;
      neg0_in = 1'b0;
      if (a_wide > upc_pkg::HALF_PI_Q29) begin
         a0_in   = a_wide - upc_pkg::PI_Q29;
         neg0_in = 1'b1;
      end else if (a_wide < -upc_pkg::HALF_PI_Q29) begin
         a0_in   = a_wide + upc_pkg::PI_Q29;
         neg0_in = 1'b1;
      end
   end

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= upc_pkg::CORDIC_K;
         y_ff[0]    <= '0;
         a_ff[0]    <= a0_in;
         neg_ff[0]  <= neg0_in;
         side_ff[0] <= in_side;
      end
   end

   // One micro-rotation per stage, driving the residual angle toward zero.
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [upc_pkg::CX_W-1:0] xs, ys;
      logic signed [upc_pkg::CX_W-1:0] x_in, y_in, a_in;
      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!a_ff[i][upc_pkg::CX_W-1]) begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            a_in = a_ff[i] - upc_pkg::atan_q29(i);
         end else begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            a_in = a_ff[i] + upc_pkg::atan_q29(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            a_ff[i+1]    <= a_in;
            neg_ff[i+1]  <= neg_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Undo the half-turn fold.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[N];
      end
      if (adv) begin
         cos_ff      <= neg_ff[N] ? upc_pkg::COS_W'(-x_ff[N])
                                  : upc_pkg::COS_W'(x_ff[N]);
         out_side_ff <= side_ff[N];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_cos   = cos_ff;
   assign out_side  = out_side_ff;

endmodule

// ----- src/unicycle_point_controller.sv -----
// Top level: go-to-point controller for a differential-drive robot.
// Each item passes through the bearing CORDIC, the bit-per-stage square root and the cosine
// CORDIC, with registered arithmetic stages before, between and after them.
// Throughput is one item per cycle; all stages advance together, so a held result
// stalls the whole pipeline without dropping anything.
// Synchronous reset clears all valid bits and loads the default register values.
`timescale 1ns / 1ps
module unicycle_point_controller (
   input  logic                               clock,
   input  logic                               reset,
   // target_x, target_y, pose_x, pose_y, pose_heading, zero pad
   input  logic [upc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // left_speed, right_speed
   output logic [upc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // at_target
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [upc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [upc_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers
   logic [upc_pkg::GAIN_W-1:0] ang_gain_ff, lin_gain_ff, ang_lim_ff;
   logic [upc_pkg::LEN_W-1:0]  lin_lim_ff, tol_ff, arm_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_gain_ff <= 16'd4915;
         lin_gain_ff <= 16'd4096;
         ang_lim_ff  <= 16'd12288;
         lin_lim_ff  <= 19'd39322;
         tol_ff      <= 19'd4588;
         arm_ff      <= 19'd4588;
      end else if (csr_valid) begin
         unique case (csr_index)
            upc_pkg::CSR_ANGULAR_GAIN: ang_gain_ff <= csr_data[upc_pkg::GAIN_W-1:0];
            upc_pkg::CSR_LINEAR_GAIN:  lin_gain_ff <= csr_data[upc_pkg::GAIN_W-1:0];
            upc_pkg::CSR_ANGULAR_LIM:  ang_lim_ff  <= csr_data[upc_pkg::GAIN_W-1:0];
            upc_pkg::CSR_LINEAR_LIM:   lin_lim_ff  <= csr_data;
            upc_pkg::CSR_POS_TOL:      tol_ff      <= csr_data;
            upc_pkg::CSR_WHEEL_ARM:    arm_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves when the output register can take an item.
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Unpack the request.
   logic signed [upc_pkg::COORD_W-1:0] tx, ty, px, py;
   logic signed [upc_pkg::HEAD_W-1:0]  hd;
   assign tx = req_tdata[19:0];
   assign ty = req_tdata[39:20];
   assign px = req_tdata[59:40];
   assign py = req_tdata[79:60];
   assign hd = req_tdata[97:80];

   // Stage 1: vector to the target.
   logic                               v1_ff;
   logic signed [upc_pkg::DIFF_W-1:0]  dx1_ff, dy1_ff;
   logic signed [upc_pkg::HEAD_W-1:0]  hd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         dx1_ff <= {tx[upc_pkg::COORD_W-1], tx} - {px[upc_pkg::COORD_W-1], px};
         dy1_ff <= {ty[upc_pkg::COORD_W-1], ty} - {py[upc_pkg::COORD_W-1], py};
         hd1_ff <= hd;
      end
   end

   // Stage 2: squares and the squared tolerance.
   logic                                v2_ff;
   logic signed [upc_pkg::SQ_W-1:0]     sqx2_ff, sqy2_ff;
   logic [upc_pkg::TOLSQ_W-1:0]         tolsq2_ff;
   logic signed [upc_pkg::DIFF_W-1:0]   dx2_ff, dy2_ff;
   logic signed [upc_pkg::HEAD_W-1:0]   hd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         sqx2_ff   <= dx1_ff * dx1_ff;
         sqy2_ff   <= dy1_ff * dy1_ff;
         tolsq2_ff <= tol_ff * tol_ff;
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         hd2_ff    <= hd1_ff;
      end
   end

   // Stage 3: squared distance.
   logic                                v3_ff;
   logic [upc_pkg::SQ_W-1:0]            s3_ff;
   logic [upc_pkg::TOLSQ_W-1:0]         tolsq3_ff;
   logic signed [upc_pkg::DIFF_W-1:0]   dx3_ff, dy3_ff;
   logic signed [upc_pkg::HEAD_W-1:0]   hd3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         s3_ff     <= unsigned'(sqx2_ff) + unsigned'(sqy2_ff);
         tolsq3_ff <= tolsq2_ff;
         dx3_ff    <= dx2_ff;
         dy3_ff    <= dy2_ff;
         hd3_ff    <= hd2_ff;
      end
   end

   // Bearing CORDIC, with the tolerance test riding along.
   upc_pkg::vec_side_type             vec_side_in, vec_side_out;
   logic                              vec_valid;
   logic signed [upc_pkg::CX_W-1:0]   vec_z;

   always_comb begin
      vec_side_in.s    = s3_ff;
      vec_side_in.near = s3_ff <= {4'b0, tolsq3_ff};
      vec_side_in.head = hd3_ff;
   end

   upc_vec_cordic u_vec (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_dx     (dx3_ff),
      .in_dy     (dy3_ff),
      .in_side   (vec_side_in),
      .out_valid (vec_valid),
      .out_z     (vec_z),
      .out_side  (vec_side_out)
   );

   // Distance.
   upc_pkg::root_side_type           root_side_in, root_side_out;
   logic                             root_valid;
   logic [upc_pkg::ROOT_W-1:0]       root_d;

   always_comb begin
      root_side_in.z    = vec_z;
      root_side_in.near = vec_side_out.near;
      root_side_in.head = vec_side_out.head;
   end

   upc_isqrt u_root (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vec_valid),
      .in_s      (vec_side_out.s),
      .in_side   (root_side_in),
      .out_valid (root_valid),
      .out_root  (root_d),
      .out_side  (root_side_out)
   );

   // W1..W4: heading error, wrapped to [-pi, pi) and rounded to Q3.15.
   logic                               w1_v_ff, w2_v_ff, w3_v_ff, w4_v_ff;
   logic signed [upc_pkg::ERR_W-1:0]   err1_ff, err2_ff, err3_ff;
   logic signed [upc_pkg::E_W-1:0]     e4_ff;
   logic [upc_pkg::ROOT_W-1:0]         d1_ff, d2_ff, d3_ff, d4_ff;
   logic                               n1_ff, n2_ff, n3_ff, n4_ff;
   logic signed [upc_pkg::ERR_W-1:0]   err1_in, err2_in, err3_in, err3_rnd;

   always_comb begin
      err1_in = {root_side_out.z[upc_pkg::CX_W-1], root_side_out.z}
              - {{3{root_side_out.head[upc_pkg::HEAD_W-1]}}, root_side_out.head, 14'b0}
              + upc_pkg::PI_E;
      // The raw sum lies within two turns either side of zero.
      err2_in = err1_ff[upc_pkg::ERR_W-1] ? err1_ff + upc_pkg::FOUR_PI_E : err1_ff;
      if (err2_ff >= upc_pkg::TWO_PI_E) begin
         err3_in = err2_ff - upc_pkg::TWO_PI_E - upc_pkg::PI_E;
      end else begin
         err3_in = err2_ff - upc_pkg::PI_E;
      end
      err3_rnd = (err3_ff + upc_pkg::ERR_W'(8192)) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_v_ff <= 1'b0;
         w2_v_ff <= 1'b0;
         w3_v_ff <= 1'b0;
         w4_v_ff <= 1'b0;
      end else if (adv) begin
         w1_v_ff <= root_valid;
         w2_v_ff <= w1_v_ff;
         w3_v_ff <= w2_v_ff;
         w4_v_ff <= w3_v_ff;
      end
      if (adv) begin
         err1_ff <= err1_in;
         err2_ff <= err2_in;
         err3_ff <= err3_in;
         e4_ff   <= err3_rnd[upc_pkg::E_W-1:0];
         d1_ff   <= root_d;
         d2_ff   <= d1_ff;
         d3_ff   <= d2_ff;
         d4_ff   <= d3_ff;
         n1_ff   <= root_side_out.near;
         n2_ff   <= n1_ff;
         n3_ff   <= n2_ff;
         n4_ff   <= n3_ff;
      end
   end

   // A1: gain products.
   logic                              a1_v_ff;
   logic signed [34:0]                wp1_ff;
   logic [36:0]                       kp1_ff;
   logic signed [upc_pkg::E_W-1:0]    ea1_ff;
   logic                              na1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff <= 1'b0;
      end else if (adv) begin
         a1_v_ff <= w4_v_ff;
      end
      if (adv) begin
         wp1_ff <= $signed({1'b0, ang_gain_ff}) * e4_ff;
         kp1_ff <= lin_gain_ff * d4_ff;
         ea1_ff <= e4_ff;
         na1_ff <= n4_ff;
      end
   end

   // A2: round, and clamp the angular speed.
   logic                              a2_v_ff;
   logic signed [upc_pkg::W_W-1:0]    w2_ff;
   logic [upc_pkg::KD_W-1:0]          kd2_ff;
   logic signed [upc_pkg::E_W-1:0]    ea2_ff;
   logic                              na2_ff;
   logic signed [34:0]                wr_full;
   logic signed [23:0]                wr, wl, w_in;
   logic [36:0]                       kd_full;

   always_comb begin
      wr_full = (wp1_ff + 35'sd1024) >>> 11;
      wr      = wr_full[23:0];
      wl      = $signed({4'b0, ang_lim_ff, 4'b0});
      if (wr > wl) begin
         w_in = wl;
      end else if (wr < -wl) begin
         w_in = -wl;
      end else begin
         w_in = wr;
      end
      kd_full = (kp1_ff + 37'd2048) >> 12;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_v_ff <= 1'b0;
      end else if (adv) begin
         a2_v_ff <= a1_v_ff;
      end
      if (adv) begin
         w2_ff  <= w_in[upc_pkg::W_W-1:0];
         kd2_ff <= kd_full[upc_pkg::KD_W-1:0];
         ea2_ff <= ea1_ff;
         na2_ff <= na1_ff;
      end
   end

   // A3: wheel arm times angular speed.
   logic                              a3_v_ff;
   logic signed [40:0]                rp3_ff;
   logic [upc_pkg::KD_W-1:0]          kd3_ff;
   logic signed [upc_pkg::E_W-1:0]    ea3_ff;
   logic                              na3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a3_v_ff <= 1'b0;
      end else if (adv) begin
         a3_v_ff <= a2_v_ff;
      end
      if (adv) begin
         rp3_ff <= $signed({1'b0, arm_ff}) * w2_ff;
         kd3_ff <= kd2_ff;
         ea3_ff <= ea2_ff;
         na3_ff <= na2_ff;
      end
   end

   // Cosine of the heading error.
   upc_pkg::cos_side_type             cos_side_in, cos_side_out;
   logic                              cos_valid;
   logic signed [upc_pkg::COS_W-1:0]  cos_val;
   logic signed [40:0]                r_full;

   always_comb begin
      r_full           = (rp3_ff + 41'sd32768) >>> 16;
      cos_side_in.near = na3_ff;
      cos_side_in.kd   = kd3_ff;
      cos_side_in.r    = r_full[upc_pkg::R_W-1:0];
   end

   upc_cos_cordic u_cos (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (a3_v_ff),
      .in_angle  (ea3_ff),
      .in_side   (cos_side_in),
      .out_valid (cos_valid),
      .out_cos   (cos_val),
      .out_side  (cos_side_out)
   );

   // V1: linear speed product.
   logic                              lv1_v_ff;
   logic signed [58:0]                pv1_ff;
   logic signed [upc_pkg::R_W-1:0]    r1_ff;
   logic                              nv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv1_v_ff <= 1'b0;
      end else if (adv) begin
         lv1_v_ff <= cos_valid;
      end
      if (adv) begin
         pv1_ff <= $signed({1'b0, cos_side_out.kd}) * cos_val;
         r1_ff  <= cos_side_out.r;
         nv1_ff <= cos_side_out.near;
      end
   end

   // V2: round and clamp the linear speed.
   logic                              lv2_v_ff;
   logic signed [upc_pkg::SPD_W-1:0]  v2s_ff;
   logic signed [upc_pkg::R_W-1:0]    r2_ff;
   logic                              nv2_ff;
   logic signed [58:0]                vr_full;
   logic signed [28:0]                vr, vl, v_in;

   always_comb begin
      vr_full = (pv1_ff + 59'sd536870912) >>> 30;
      vr      = vr_full[28:0];
      vl      = $signed({10'b0, lin_lim_ff});
      if (vr > vl) begin
         v_in = vl;
      end else if (vr < -vl) begin
         v_in = -vl;
      end else begin
         v_in = vr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv2_v_ff <= 1'b0;
      end else if (adv) begin
         lv2_v_ff <= lv1_v_ff;
      end
      if (adv) begin
         v2s_ff <= v_in[upc_pkg::SPD_W-1:0];
         r2_ff  <= r1_ff;
         nv2_ff <= nv1_ff;
      end
   end

   // Output register: wheel mixing with saturation, or a stop at the target.
   logic signed [upc_pkg::SPD_W-1:0]  left_ff, right_ff;
   logic                              at_ff;
   logic signed [25:0]                vx, rx, lsum, rsum;
   logic signed [upc_pkg::SPD_W-1:0]  left_in, right_in;

   always_comb begin
      vx   = {{6{v2s_ff[upc_pkg::SPD_W-1]}}, v2s_ff};
      rx   = {r2_ff[upc_pkg::R_W-1], r2_ff};
      lsum = vx - rx;
      rsum = vx + rx;
      if (lsum > 26'sd524287) begin
         left_in = 20'sd524287;
      end else if (lsum < -26'sd524288) begin
         left_in = -20'sd524288;
      end else begin
         left_in = lsum[upc_pkg::SPD_W-1:0];
      end
      if (rsum > 26'sd524287) begin
         right_in = 20'sd524287;
      end else if (rsum < -26'sd524288) begin
         right_in = -20'sd524288;
      end else begin
         right_in = rsum[upc_pkg::SPD_W-1:0];
      end
      if (nv2_ff) begin
         left_in  = '0;
         right_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= lv2_v_ff;
      end
      if (adv) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         at_ff    <= nv2_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = at_ff;

endmodule

// ----- src/upc_checker.sv -----
// Port-level checks for the point controller, bound to the top level.
`timescale 1ns / 1ps
module upc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic [upc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);

   // After reset no result item is offered.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // With the output empty the pipeline must take a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register is empty");

   // A robot at the target commands both wheels to zero.
   a_stop_at_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("nonzero wheel speed at target");

   // A stalled result item holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind unicycle_point_controller upc_checker u_upc_checker (.*);

// ----- dv/unicycle_point_controller_tb.sv -----
// Self-checking testbench for the unicycle go-to-point controller.
`timescale 1ns / 1ps
module unicycle_point_controller_tb;

   // Register indexes past the end of the map; writes to them must be dropped.
   localparam logic [upc_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [upc_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int  STALL_LIMIT  = 3000;
   localparam int  DRAIN_CYCLES = 100;
   localparam longint PI_FIX     = 64'sd1686629713;
   localparam longint HALF_PI    = 64'sd843314857;
   localparam longint TWO_PI_FIX = 64'sd3373259426;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint ARCTAN [24] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096,
      2048, 1024, 512, 256, 128, 64};

   typedef struct {
      logic signed [upc_pkg::SPD_W-1:0] left;
      logic signed [upc_pkg::SPD_W-1:0] right;
      logic                             at_target;
   } wheel_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [upc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [upc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [upc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [upc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the control registers.
   longint ang_gain, lin_gain, ang_limit, lin_limit, pos_tol, wheel_arm;

   wheel_cmd_type pending_cmds[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  rsp_stall_left = 0;
   bit  quiet = 1'b0;

   unicycle_point_controller dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Round half up: add half an LSB, then shift arithmetically.
   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint int_sqrt(longint s_in);
      longint s, res, bit_val;
      s = s_in;
      res = 0;
      bit_val = 64'sd1 <<< 40;
      while (bit_val > s) bit_val = bit_val >>> 2;
      while (bit_val != 0) begin
         if (s >= res + bit_val) begin
            s = s - (res + bit_val);
            res = (res >>> 1) + bit_val;
         end else begin
            res = res >>> 1;
         end
         bit_val = bit_val >>> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC: angle of (dx, dy) in Q3.29.
   function automatic longint bearing_angle(longint dx, longint dy);
      longint x, y, z, xs, ys;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_FIX : -PI_FIX;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < upc_pkg::CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARCTAN[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARCTAN[i];
         end
      end
      return z;
   endfunction

   // Rotation CORDIC: cosine in Q2.30, folded into the right half plane.
   function automatic longint cosine_q30(longint a_in);
      longint a, x, y, xs, ys;
      bit neg;
      a = a_in;
      x = CORDIC_GAIN;
      y = 0;
      neg = 1'b0;
      if (a > HALF_PI) begin
         a = a - PI_FIX; neg = 1'b1;
      end else if (a < -HALF_PI) begin
         a = a + PI_FIX; neg = 1'b1;
      end
      for (int i = 0; i < upc_pkg::CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (a >= 0) begin
            x = x - ys; y = y + xs; a = a - ARCTAN[i];
         end else begin
            x = x + ys; y = y - xs; a = a + ARCTAN[i];
         end
      end
      return neg ? -x : x;
   endfunction

   // Wheel commands for one pose under the current register settings.
   function automatic wheel_cmd_type predict_wheels(logic [upc_pkg::REQ_DATA_W-1:0] pose);
      wheel_cmd_type cmd;
      longint dx, dy, head, s, d, err, e15, w, c, kd, v, r;
      dx = longint'($signed(pose[19:0])) - longint'($signed(pose[59:40]));
      dy = longint'($signed(pose[39:20])) - longint'($signed(pose[79:60]));
      head = longint'($signed(pose[97:80]));
      s = dx * dx + dy * dy;
      cmd.left = '0;
      cmd.right = '0;
      cmd.at_target = 1'b1;
      if (s <= pos_tol * pos_tol) return cmd;
      d = int_sqrt(s);
      // Heading error wrapped into [-pi, pi).
      err = bearing_angle(dx, dy) - head * 16384 + PI_FIX;
      err = err % TWO_PI_FIX;
      if (err < 0) err = err + TWO_PI_FIX;
      err = err - PI_FIX;
      e15 = round_shift(err, 14);
      w = clip(round_shift(ang_gain * e15, 11), -ang_limit * 16, ang_limit * 16);
      c = cosine_q30(e15 * 16384);
      kd = round_shift(lin_gain * d, 12);
      v = clip(round_shift(kd * c, 30), -lin_limit, lin_limit);
      r = round_shift(wheel_arm * w, 16);
      cmd.left = upc_pkg::SPD_W'(clip(v - r, -524288, 524287));
      cmd.right = upc_pkg::SPD_W'(clip(v + r, -524288, 524287));
      cmd.at_target = 1'b0;
      return cmd;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Result checker: compares every accepted item with the oldest prediction.
   always @(posedge clock) begin
      wheel_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            report("unexpected item", 0, 0);
         end else begin
            want = pending_cmds.pop_front();
            if ($signed(rsp_tdata[19:0]) != want.left)
               report("left_speed", $signed(rsp_tdata[19:0]), want.left);
            if ($signed(rsp_tdata[39:20]) != want.right)
               report("right_speed", $signed(rsp_tdata[39:20]), want.right);
            if (rsp_tuser != want.at_target)
               report("at_target", rsp_tuser, want.at_target);
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles with no traffic on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("unicycle_point_controller_tb failed");
            $finish;
         end
      end
   end

   // Writes one register; valid drops for a cycle before the next write.
   task automatic write_reg(logic [upc_pkg::CSR_IDX_W-1:0] idx,
                            logic [upc_pkg::CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         upc_pkg::CSR_ANGULAR_GAIN: ang_gain = value[15:0];
         upc_pkg::CSR_LINEAR_GAIN:  lin_gain = value[15:0];
         upc_pkg::CSR_ANGULAR_LIM:  ang_limit = value[15:0];
         upc_pkg::CSR_LINEAR_LIM:   lin_limit = value;
         upc_pkg::CSR_POS_TOL:      pos_tol = value;
         upc_pkg::CSR_WHEEL_ARM:    wheel_arm = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one pose; valid stays high unless a gap follows.
   task automatic send_pose(logic [19:0] tx, logic [19:0] ty, logic [19:0] px,
                            logic [19:0] py, logic [17:0] hd);
      int gap;
      req_tdata <= {6'b0, hd, py, px, ty, tx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pending_cmds.push_back(predict_wheels(req_tdata));
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every result is in and the pipeline has emptied.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [upc_pkg::CSR_DATA_W-1:0] pick_value(int width);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return upc_pkg::CSR_DATA_W'((64'd1 << width) - 1);
         default: return upc_pkg::CSR_DATA_W'($urandom_range(0, (1 << width) - 1));
      endcase
   endfunction

   task automatic random_pose(bit near);
      logic [19:0] px, py, tx, ty;
      px = 20'($urandom);
      py = 20'($urandom);
      if (near) begin
         tx = px + 20'($signed($urandom_range(0, 16000)) - 8000);
         ty = py + 20'($signed($urandom_range(0, 16000)) - 8000);
      end else begin
         tx = 20'($urandom);
         ty = 20'($urandom);
      end
      send_pose(tx, ty, px, py, 18'($urandom));
   endtask

   // Extremes of the fields and each special case, first under reset settings, then under large settings.
   task automatic test_directed;
      send_pose(20'sd1000, 20'sd1000, 20'sd1000, 20'sd1000, 18'sd0);
      send_pose(20'sd4588, 20'sd0, 20'sd0, 20'sd0, 18'sd0);
      send_pose(20'sd4589, 20'sd0, 20'sd0, 20'sd0, 18'sd0);
      send_pose(-20'sd100000, 20'sd5000, 20'sd0, 20'sd0, 18'sd0);
      send_pose(-20'sd100000, -20'sd5000, 20'sd0, 20'sd0, 18'sd0);
      send_pose(20'sd0, -20'sd100000, 20'sd0, 20'sd0, 18'sd51472);
      send_pose(20'sd0, 20'sd100000, 20'sd0, 20'sd0, -18'sd51472);
      send_pose(20'sd524287, 20'sd524287, 20'h80000, 20'h80000, 18'sd131071);
      send_pose(20'h80000, 20'h80000, 20'sd524287, 20'sd524287, 18'h20000);
      send_pose(20'h80000, 20'sd0, 20'sd524287, 20'sd0, 18'sd0);
      send_pose(20'sd200000, 20'sd0, 20'sd0, 20'sd0, 18'sd102944);
      send_pose(20'sd200000, 20'sd0, 20'sd0, 20'sd0, -18'sd102944);
      drain();
      // Large gains and arm drive the wheels into saturation.
      write_reg(upc_pkg::CSR_ANGULAR_GAIN, 19'h7ffff);
      write_reg(upc_pkg::CSR_LINEAR_GAIN, 19'h0ffff);
      write_reg(upc_pkg::CSR_ANGULAR_LIM, 19'h0ffff);
      write_reg(upc_pkg::CSR_LINEAR_LIM, 19'h7ffff);
      write_reg(upc_pkg::CSR_POS_TOL, 19'd0);
      write_reg(upc_pkg::CSR_WHEEL_ARM, 19'h7ffff);
      write_reg(CSR_SPARE_A, 19'd1);
      write_reg(CSR_SPARE_B, 19'd1);
      send_pose(20'sd524287, 20'sd100, 20'h80000, 20'sd0, 18'sd30000);
      send_pose(20'sd0, 20'sd524287, 20'sd0, 20'h80000, 18'h20000);
      send_pose(20'sd1, 20'sd0, 20'sd0, 20'sd0, 18'sd0);
      send_pose(20'sd5, 20'sd5, 20'sd5, 20'sd5, 18'sd0);
      drain();
   endtask

   // Register extremes, with all gains and limits at zero.
   task automatic test_zero_settings;
      write_reg(upc_pkg::CSR_ANGULAR_GAIN, 19'd0);
      write_reg(upc_pkg::CSR_LINEAR_GAIN, 19'd0);
      write_reg(upc_pkg::CSR_ANGULAR_LIM, 19'd0);
      write_reg(upc_pkg::CSR_LINEAR_LIM, 19'd0);
      write_reg(upc_pkg::CSR_POS_TOL, 19'h7ffff);
      write_reg(upc_pkg::CSR_WHEEL_ARM, 19'd0);
      repeat (20) random_pose(1'b0);
      drain();
   endtask

   // Random phases, each under fresh random settings.
   task automatic test_random_phases(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_reg(upc_pkg::CSR_ANGULAR_GAIN, pick_value(19));
         write_reg(upc_pkg::CSR_LINEAR_GAIN, pick_value(19));
         write_reg(upc_pkg::CSR_ANGULAR_LIM, pick_value(16));
         write_reg(upc_pkg::CSR_LINEAR_LIM, pick_value(19));
         write_reg(upc_pkg::CSR_POS_TOL, ($urandom_range(0, 3) == 0) ? pick_value(19)
                   : upc_pkg::CSR_DATA_W'($urandom_range(0, 9000)));
         write_reg(upc_pkg::CSR_WHEEL_ARM, pick_value(19));
         for (int i = 0; i < per_phase; i++) begin
            random_pose($urandom_range(0, 2) == 0);
            // Hold off once mid-phase until all results are back.
            if (p == 1 && i == per_phase / 2) drain();
         end
         drain();
      end
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate;
      quiet = 1'b1;
      write_reg(upc_pkg::CSR_ANGULAR_GAIN, 19'd4915);
      write_reg(upc_pkg::CSR_LINEAR_GAIN, 19'd4096);
      write_reg(upc_pkg::CSR_ANGULAR_LIM, 19'd12288);
      write_reg(upc_pkg::CSR_LINEAR_LIM, 19'd39322);
      write_reg(upc_pkg::CSR_POS_TOL, 19'd4588);
      write_reg(upc_pkg::CSR_WHEEL_ARM, 19'd4588);
      repeat (200) random_pose($urandom_range(0, 1) == 0);
      drain();
   endtask

   initial begin
      ang_gain = 4915;
      lin_gain = 4096;
      ang_limit = 12288;
      lin_limit = 39322;
      pos_tol = 4588;
      wheel_arm = 4588;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_zero_settings();
      test_random_phases(6, 250);
      test_full_rate();
      if (error_count == 0) begin
         $display("unicycle_point_controller_tb passed");
      end else begin
         $display("unicycle_point_controller_tb failed");
      end
      $finish;
   end

endmodule
